// ----- hdl/rcbp_pkg.sv -----
package rcbp_pkg;

  localparam int FREQ_BUF_LEN_DEF  = 16;
  localparam int PARAM_BUF_LEN_DEF = 4;

  localparam logic [1:0] MODE_WAITING = 2'd0;
  localparam logic [1:0] MODE_FREQ    = 2'd1;
  localparam logic [1:0] MODE_PARAM   = 2'd2;

  localparam logic [7:0] CHAR_K  = 8'h4b;
  localparam logic [7:0] CHAR_J  = 8'h4a;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;

  localparam logic [3:0] POS_FIRST   = 4'd1;
  localparam logic [3:0] POS_LAST    = 4'd10;
  localparam logic [3:0] POS_MOD_LO  = 4'd11;
  localparam logic [3:0] POS_MOD_HI  = 4'd12;
  localparam logic [3:0] POS_FIL_LO  = 4'd13;
  localparam logic [3:0] POS_FIL_HI  = 4'd14;
  localparam int         FBUF_STORE  = 14;
  localparam int         PBUF_STORE  = 4;

  localparam logic [2:0] PARAM_VOLUME  = 3'd0;
  localparam logic [2:0] PARAM_SQUELCH = 3'd1;
  localparam logic [2:0] PARAM_IFSHIFT = 3'd2;
  localparam logic [2:0] PARAM_AGC     = 3'd3;
  localparam logic [2:0] PARAM_BLANKER = 3'd4;
  localparam logic [2:0] PARAM_ATTEN   = 3'd5;
  localparam logic [2:0] PARAM_NONE    = 3'd6;

  localparam logic [7:0] MOD_MAX     = 8'd6;
  localparam logic [7:0] MOD_WFM     = 8'd6;
  localparam logic [7:0] FIL_MAX     = 8'd4;
  localparam logic [2:0] FIL_230K    = 3'd4;
  localparam logic [2:0] DISP_MOD_RST = 3'd3;
  localparam logic [2:0] DISP_FIL_RST = 3'd0;

  typedef struct packed {
    logic busy;
    logic done;
  } dec_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      t = c - CHAR_0;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      t = c - CHAR_UA + 8'd10;
    end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
      t = c - CHAR_LA + 8'd10;
    end
    return t[3:0];
  endfunction

  function automatic logic [2:0] param_from_xor(input logic [7:0] x);
    logic [2:0] id;
    unique case (x)
      8'h04:   id = PARAM_VOLUME;
      8'h05:   id = PARAM_SQUELCH;
      8'h07:   id = PARAM_IFSHIFT;
      8'h01:   id = PARAM_AGC;
      8'h02:   id = PARAM_BLANKER;
      8'h03:   id = PARAM_ATTEN;
      default: id = PARAM_NONE;
    endcase
    return id;
  endfunction

endpackage

// ----- hdl/rcbp_dec_unit.sv -----
module rcbp_dec_unit
  import rcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        ack,
  input  logic [7:0]  rd_byte,
  output logic [3:0]  rd_pos,
  output dec_stat_t   stat,
  output logic [31:0] value
);

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_RUN  = 2'd1;
  localparam logic [1:0] DS_DONE = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        skip_r, skip_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  digit;

  assign digit = rd_byte - CHAR_0;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    skip_nxt  = skip_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      DS_IDLE: begin
        if (start) begin
          state_nxt = DS_RUN;
          pos_nxt   = POS_FIRST;
          skip_nxt  = 1'b1;
          acc_nxt   = 32'd0;
        end
      end
      DS_RUN: begin
        if (pos_r > POS_LAST) begin
          state_nxt = DS_DONE;
        end else if (skip_r && rd_byte == CHAR_CR) begin
          pos_nxt = pos_r + 4'd1;
        end else if (!is_digit(rd_byte)) begin
          state_nxt = DS_DONE;
        end else begin
          // multiply-add: acc * 10 + digit
          acc_nxt  = (acc_r << 3) + (acc_r << 1) + {28'd0, digit[3:0]};
          skip_nxt = 1'b0;
          pos_nxt  = pos_r + 4'd1;
        end
      end
      DS_DONE: begin
        if (ack) begin
          state_nxt = DS_IDLE;
        end
      end
      default: state_nxt = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pos_r  <= pos_nxt;
    skip_r <= skip_nxt;
    acc_r  <= acc_nxt;
  end

  assign rd_pos    = pos_r;
  assign stat.busy = (state_r != DS_IDLE);
  assign stat.done = (state_r == DS_DONE);
  assign value     = acc_r;

endmodule

// ----- hdl/radio_command_byte_parser_core.sv -----
// output: a parameter result is shown the cycle after its line feed transfer, which
//   waits on a stalled output; frequency results once decoding is done and output is free
// throughput: one byte per cycle, except a frequency line feed blocks input until its
//   result is loaded, set by the one-digit-per-cycle decimal multiply-add loop
// reset: synchronous active low, clears mode, indexes, buffers and bridge_mode,
//   display codes return to cw and 2.8k
module radio_command_byte_parser_core
  import rcbp_pkg::*;
#(
  parameter int FREQ_BUF_LEN  = FREQ_BUF_LEN_DEF,
  parameter int PARAM_BUF_LEN = PARAM_BUF_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_applied,
  output logic [31:0] out_frequency,
  output logic [7:0]  out_modulation_code,
  output logic [7:0]  out_filter_code,
  output logic [2:0]  out_shown_modulation,
  output logic [2:0]  out_shown_filter,
  output logic [2:0]  out_param_id,
  output logic [7:0]  out_param_value
);

  localparam int FIDX_W = $clog2(FREQ_BUF_LEN + 1);
  localparam int PIDX_W = $clog2(PARAM_BUF_LEN);
  localparam int PCMP_W = PIDX_W + 1;

  logic              bridge_r;
  logic [1:0]        mode_r, mode_nxt;
  logic [FIDX_W-1:0] fidx_r, fidx_nxt;
  logic [PIDX_W-1:0] pidx_r, pidx_nxt;
  logic [7:0]        fbuf_r [1:FBUF_STORE];
  logic [7:0]        pbuf_r [0:PBUF_STORE-1];
  logic [2:0]        dmod_r, dmod_nxt;
  logic [2:0]        dfil_r, dfil_nxt;
  logic              out_valid_r;

  dec_stat_t   dec_stat;
  logic [3:0]  dec_pos;
  logic [31:0] dec_value;
  logic        dec_start;
  logic        dec_ack;

  logic        xfer_in;
  logic        out_free;
  logic        is_freq_char;
  logic        param_lf;
  logic        fbuf_we;
  logic        pbuf_we;
  logic [7:0]  mod_code;
  logic [7:0]  fil_code;
  logic [2:0]  pid;
  logic [7:0]  pval;
  logic        papplied;

  assign out_free     = !out_valid_r || !out_stall;
  assign param_lf     = (mode_r == MODE_PARAM) && (in_byte == CHAR_LF);
  assign in_stall     = dec_stat.busy || (param_lf && !out_free);
  assign xfer_in      = in_valid && !in_stall;
  assign is_freq_char = is_digit(in_byte) || (in_byte == CHAR_CR);

  assign mod_code = fbuf_r[POS_MOD_HI] - fbuf_r[POS_MOD_LO];
  assign fil_code = fbuf_r[POS_FIL_HI] - fbuf_r[POS_FIL_LO];
  assign pid      = param_from_xor(pbuf_r[0] ^ pbuf_r[1]);
  assign pval     = {hex_nibble(pbuf_r[2]), hex_nibble(pbuf_r[3])};
  assign papplied = bridge_r && (pid != PARAM_NONE);

  always_comb begin
    mode_nxt  = mode_r;
    fidx_nxt  = fidx_r;
    pidx_nxt  = pidx_r;
    dmod_nxt  = dmod_r;
    dfil_nxt  = dfil_r;
    fbuf_we   = 1'b0;
    pbuf_we   = 1'b0;
    dec_start = 1'b0;
    if (xfer_in) begin
      unique case (mode_r)
        MODE_FREQ: begin
          if (is_freq_char) begin
            if (fidx_r < FIDX_W'(FREQ_BUF_LEN)) begin
              fbuf_we  = (fidx_r >= FIDX_W'(1)) && (fidx_r <= FIDX_W'(FBUF_STORE));
              fidx_nxt = fidx_r + FIDX_W'(1);
            end
          end else begin
            fidx_nxt = '0;
            mode_nxt = MODE_WAITING;
            if (in_byte == CHAR_LF) begin
              dec_start = 1'b1;
              if (mod_code <= MOD_MAX) begin
                dmod_nxt = mod_code[2:0];
                if (mod_code == MOD_WFM) begin
                  dfil_nxt = FIL_230K;
                end
              end
              if (fil_code <= FIL_MAX) begin
                dfil_nxt = fil_code[2:0];
              end
            end
          end
        end
        MODE_PARAM: begin
          if (in_byte != CHAR_LF) begin
            pbuf_we  = (PCMP_W'(pidx_r) < PCMP_W'(PBUF_STORE));
            pidx_nxt = (pidx_r == PIDX_W'(PARAM_BUF_LEN - 1)) ? '0 : pidx_r + PIDX_W'(1);
          end else if (papplied) begin
            mode_nxt = MODE_WAITING;
          end
        end
        default: begin
          if (in_byte == CHAR_K) begin
            mode_nxt = MODE_FREQ;
          end else if (in_byte == CHAR_J) begin
            mode_nxt = MODE_PARAM;
          end else begin
            mode_nxt = MODE_WAITING;
          end
        end
      endcase
    end
  end

  assign dec_ack = dec_stat.done && out_free;

  rcbp_dec_unit u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dec_start),
    .ack     (dec_ack),
    .rd_byte (fbuf_r[dec_pos]),
    .rd_pos  (dec_pos),
    .stat    (dec_stat),
    .value   (dec_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bridge_r <= 1'b0;
      mode_r   <= MODE_WAITING;
      fidx_r   <= '0;
      pidx_r   <= '0;
      dmod_r   <= DISP_MOD_RST;
      dfil_r   <= DISP_FIL_RST;
      for (int i = 1; i <= FBUF_STORE; i++) begin
        fbuf_r[i] <= 8'd0;
      end
      for (int i = 0; i < PBUF_STORE; i++) begin
        pbuf_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        bridge_r <= cfg_wdata;
      end
      mode_r <= mode_nxt;
      fidx_r <= fidx_nxt;
      pidx_r <= pidx_nxt;
      dmod_r <= dmod_nxt;
      dfil_r <= dfil_nxt;
      if (fbuf_we) begin
        fbuf_r[fidx_r[3:0]] <= in_byte;
      end
      if (pbuf_we) begin
        pbuf_r[pidx_r[1:0]] <= in_byte;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dec_ack || (xfer_in && param_lf)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ack) begin
      out_kind             <= 1'b0;
      out_applied          <= bridge_r;
      out_frequency        <= dec_value;
      out_modulation_code  <= mod_code;
      out_filter_code      <= fil_code;
      out_shown_modulation <= dmod_r;
      out_shown_filter     <= dfil_r;
      out_param_id         <= PARAM_NONE;
      out_param_value      <= 8'd0;
    end else if (xfer_in && param_lf) begin
      out_kind             <= 1'b1;
      out_applied          <= papplied;
      out_frequency        <= 32'd0;
      out_modulation_code  <= 8'd0;
      out_filter_code      <= 8'd0;
      out_shown_modulation <= dmod_r;
      out_shown_filter     <= dfil_r;
      out_param_id         <= pid;
      out_param_value      <= pval;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sim/rcbp_report_checker.sv -----
`timescale 1ns / 1ps

module rcbp_report_checker
  import rcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic        out_applied,
  input  logic [31:0] out_frequency,
  input  logic [7:0]  out_modulation_code,
  input  logic [7:0]  out_filter_code,
  input  logic [2:0]  out_shown_modulation,
  input  logic [2:0]  out_shown_filter,
  input  logic [2:0]  out_param_id,
  input  logic [7:0]  out_param_value,
  output int          n_fail,
  output int          n_pending,
  output int          n_tune,
  output int          n_knob
);

  localparam logic KIND_TUNE = 1'b0;
  localparam logic KIND_KNOB = 1'b1;

  localparam logic [7:0] XOR_VOLUME  = 8'h04;
  localparam logic [7:0] XOR_SQUELCH = 8'h05;
  localparam logic [7:0] XOR_IFSHIFT = 8'h07;
  localparam logic [7:0] XOR_AGC     = 8'h01;
  localparam logic [7:0] XOR_BLANKER = 8'h02;
  localparam logic [7:0] XOR_ATTEN   = 8'h03;

  typedef struct packed {
    logic        kind;
    logic        applied;
    logic [31:0] frequency;
    logic [7:0]  modulation_code;
    logic [7:0]  filter_code;
    logic [2:0]  shown_modulation;
    logic [2:0]  shown_filter;
    logic [2:0]  param_id;
    logic [7:0]  param_value;
  } report_t;

  report_t    pending_reports[$];
  logic       bridge;
  logic [1:0] mode;
  logic [7:0] fbuf [FREQ_BUF_LEN_DEF];
  int         fidx;
  logic [7:0] pbuf [PARAM_BUF_LEN_DEF];
  int         pidx;
  logic [2:0] disp_mod;
  logic [2:0] disp_fil;
  int         mismatches = 0;
  int         tunes = 0;
  int         knobs = 0;

  function automatic logic [31:0] digits_value();
    logic [31:0] acc;
    int          p;
    acc = '0;
    p = POS_FIRST;
    while (p <= POS_LAST && fbuf[p] == CHAR_CR) p++;
    while (p <= POS_LAST && fbuf[p] >= CHAR_0 && fbuf[p] <= CHAR_9) begin
      acc = acc * 10 + 32'(fbuf[p] - CHAR_0);
      p++;
    end
    return acc;
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      v = c - CHAR_0;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      v = c - CHAR_UA + 8'd10;
    end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
      v = c - CHAR_LA + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [2:0] knob_of(input logic [7:0] x);
    case (x)
      XOR_VOLUME:  return PARAM_VOLUME;
      XOR_SQUELCH: return PARAM_SQUELCH;
      XOR_IFSHIFT: return PARAM_IFSHIFT;
      XOR_AGC:     return PARAM_AGC;
      XOR_BLANKER: return PARAM_BLANKER;
      XOR_ATTEN:   return PARAM_ATTEN;
      default:     return PARAM_NONE;
    endcase
  endfunction

  task automatic parse_host_byte(input logic [7:0] b);
    report_t    rep;
    logic [7:0] mod_code;
    logic [7:0] fil_code;
    rep = '0;
    if (mode == MODE_FREQ) begin
      if ((b >= CHAR_0 && b <= CHAR_9) || b == CHAR_CR) begin
        if (fidx < FREQ_BUF_LEN_DEF) begin
          fbuf[fidx] = b;
          fidx++;
        end
      end else if (b != CHAR_LF) begin
        fidx = 0;
        mode = MODE_WAITING;
      end else begin
        mod_code = fbuf[POS_MOD_HI] - fbuf[POS_MOD_LO];
        fil_code = fbuf[POS_FIL_HI] - fbuf[POS_FIL_LO];
        if (mod_code <= MOD_MAX) begin
          disp_mod = mod_code[2:0];
          if (mod_code == MOD_WFM) disp_fil = FIL_230K;
        end
        if (fil_code <= FIL_MAX) disp_fil = fil_code[2:0];
        rep.kind = KIND_TUNE;
        rep.applied = bridge;
        rep.frequency = digits_value();
        rep.modulation_code = mod_code;
        rep.filter_code = fil_code;
        rep.shown_modulation = disp_mod;
        rep.shown_filter = disp_fil;
        rep.param_id = PARAM_NONE;
        pending_reports.push_back(rep);
        tunes++;
        fidx = 0;
        mode = MODE_WAITING;
      end
    end else if (mode == MODE_PARAM) begin
      if (b != CHAR_LF) begin
        pbuf[pidx] = b;
        pidx = (pidx + 1) % PARAM_BUF_LEN_DEF;
      end else begin
        rep.kind = KIND_KNOB;
        rep.param_id = knob_of(pbuf[0] ^ pbuf[1]);
        rep.applied = bridge && (rep.param_id != PARAM_NONE);
        rep.shown_modulation = disp_mod;
        rep.shown_filter = disp_fil;
        rep.param_value = {nibble_of(pbuf[2]), nibble_of(pbuf[3])};
        pending_reports.push_back(rep);
        knobs++;
        if (rep.applied) mode = MODE_WAITING;
      end
    end else begin
      if (b == CHAR_K) mode = MODE_FREQ;
      else if (b == CHAR_J) mode = MODE_PARAM;
      else mode = MODE_WAITING;
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      pending_reports.delete();
      bridge = 1'b0;
      mode = MODE_WAITING;
      foreach (fbuf[i]) fbuf[i] = '0;
      foreach (pbuf[i]) pbuf[i] = '0;
      fidx = 0;
      pidx = 0;
      disp_mod = DISP_MOD_RST;
      disp_fil = DISP_FIL_RST;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with no report expected");
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("applied", 32'(want.applied), 32'(out_applied));
          check_field("frequency", want.frequency, out_frequency);
          check_field("modulation_code", 32'(want.modulation_code),
                      32'(out_modulation_code));
          check_field("filter_code", 32'(want.filter_code), 32'(out_filter_code));
          check_field("shown_modulation", 32'(want.shown_modulation),
                      32'(out_shown_modulation));
          check_field("shown_filter", 32'(want.shown_filter), 32'(out_shown_filter));
          check_field("param_id", 32'(want.param_id), 32'(out_param_id));
          check_field("param_value", 32'(want.param_value), 32'(out_param_value));
        end
      end
      if (cfg_we) bridge = cfg_wdata;
      if (in_valid && !in_stall) parse_host_byte(in_byte);
    end
    n_fail <= mismatches;
    n_pending <= pending_reports.size();
    n_tune <= tunes;
    n_knob <= knobs;
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rcbp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] ESC_LO = 8'h00;
  localparam logic [7:0] ESC_HI = 8'h04;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic        out_applied;
  logic [31:0] out_frequency;
  logic [7:0]  out_modulation_code;
  logic [7:0]  out_filter_code;
  logic [2:0]  out_shown_modulation;
  logic [2:0]  out_shown_filter;
  logic [2:0]  out_param_id;
  logic [7:0]  out_param_value;

  int n_fail;
  int n_pending;
  int n_tune;
  int n_knob;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  bit param_open = 1'b0;

  radio_command_byte_parser_core i_dut (.*);

  rcbp_report_checker i_checker (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output stall, with a long hold on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_bridge(input logic on);
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // adjacent pairs all select volume, so it lands whatever the buffer index
  task automatic send_escape();
    put_byte(ESC_LO);
    put_byte(ESC_HI);
    put_byte(ESC_LO);
    put_byte(ESC_HI);
    put_byte(CHAR_LF);
  endtask

  task automatic send_tune();
    logic [7:0] body [18];
    int len;
    int lead;
    int k;
    int r;
    logic [7:0] stray;
    len = ($urandom_range(9) < 7) ? $urandom_range(15, 16) : $urandom_range(0, 18);
    lead = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
    for (int p = 0; p < 18; p++) begin
      if (p >= 1 && p <= lead) body[p] = CHAR_CR;
      else if ($urandom_range(19) == 0) body[p] = CHAR_CR;
      else body[p] = CHAR_0 + 8'($urandom_range(9));
    end
    if ($urandom_range(4) != 0) begin
      k = $urandom_range(7);
      body[POS_MOD_LO] = CHAR_0 + 8'($urandom_range(9 - k));
      body[POS_MOD_HI] = body[POS_MOD_LO] + 8'(k);
    end
    if ($urandom_range(4) != 0) begin
      k = $urandom_range(5);
      body[POS_FIL_LO] = CHAR_0 + 8'($urandom_range(9 - k));
      body[POS_FIL_HI] = body[POS_FIL_LO] + 8'(k);
    end
    put_byte(CHAR_K);
    for (int p = 0; p < len; p++) put_byte(body[p]);
    r = $urandom_range(19);
    if (r < 17) begin
      put_byte(CHAR_LF);
    end else if (r < 19) begin
      do stray = 8'($urandom_range(255));
      while ((stray >= CHAR_0 && stray <= CHAR_9) || stray == CHAR_CR || stray == CHAR_LF);
      put_byte(stray);
    end
  endtask

  task automatic send_knob_body();
    logic [7:0] c [4];
    int style;
    style = $urandom_range(9);
    if (style < 6) begin
      foreach (c[i]) c[i] = CHAR_0 + 8'($urandom_range(7));
    end else begin
      c[0] = 8'($urandom_range(255));
      c[1] = c[0] ^ 8'($urandom_range(7));
      for (int i = 2; i < 4; i++) begin
        case ($urandom_range(3))
          0: c[i] = CHAR_0 + 8'($urandom_range(9));
          1: c[i] = CHAR_UA + 8'($urandom_range(5));
          2: c[i] = CHAR_LA + 8'($urandom_range(5));
          default: c[i] = 8'($urandom_range(255));
        endcase
      end
    end
    foreach (c[i]) put_byte(c[i]);
    put_byte(CHAR_LF);
  endtask

  task automatic send_noise(input bit allow_j);
    logic [7:0] b;
    int r;
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(9);
      if (r < 3) b = CHAR_LF;
      else if (r == 3) b = CHAR_K;
      else b = 8'($urandom_range(255));
      if (!allow_j && b == CHAR_J) b = CHAR_LF;
      put_byte(b);
    end
  endtask

  task automatic run_phase(input int budget, input logic bridge, input int idle_pct,
                           input int stall_pct);
    int start;
    int r;
    settle();
    write_bridge(bridge);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(99);
      if (bridge) begin
        send_escape();
        if (r < 45) begin
          send_tune();
        end else if (r < 90) begin
          put_byte(CHAR_J);
          send_knob_body();
        end else begin
          send_noise(1'b1);
        end
      end else if (!param_open && bytes_sent - start < budget * 3 / 5) begin
        if (r < 85) send_tune();
        else send_noise(1'b0);
      end else begin
        // without bridge mode the parameter parser never lets go
        if (!param_open) begin
          put_byte(CHAR_J);
          param_open = 1'b1;
        end
        if (r < 85) send_knob_body();
        else send_noise(1'b1);
      end
    end
    if (bridge) begin
      send_escape();
      param_open = 1'b0;
    end
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_bridge(1'b0);

    put_byte(8'hff);
    put_byte(CHAR_K);
    put_byte(CHAR_UA);
    put_byte(CHAR_K);
    put_byte(CHAR_CR);
    repeat (10) put_byte(CHAR_9);
    put_byte(CHAR_0);
    put_byte(CHAR_0 + MOD_WFM);
    put_byte(CHAR_0);
    put_byte(CHAR_0 + FIL_MAX);
    put_byte(CHAR_9);
    put_byte(CHAR_9);
    put_byte(CHAR_LF);
    put_byte(CHAR_J);
    put_byte(ESC_LO);
    put_byte(ESC_HI);
    put_byte(CHAR_LF_HEX);
    put_byte(CHAR_UA);
    put_byte(CHAR_LF);
    settle();
    write_bridge(1'b1);
    put_byte(CHAR_LF);

    run_phase(420, 1'b0, 0, 0);
    run_phase(420, 1'b1, 46, 0);
    run_phase(420, 1'b0, 0, 46);
    param_open = 1'b0;
    run_phase(420, 1'b1, 15, 15);

    // output held off while the sender keeps going
    write_bridge(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    put_byte(CHAR_J);
    hold_go = 1'b1;
    repeat (60) begin
      put_byte(8'($urandom_range(11, 255)));
      put_byte(CHAR_LF);
    end
    settle();

    $display("covered %0d host bytes: %0d frequency and %0d parameter reports checked",
             bytes_sent, n_tune, n_knob);
    $display("bridge mode off and on, four idle mixes, one long output hold");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
